FILE: hw/rtl/mns_pkg.sv
// Shared types and constants for the melody note sequencer.
// Depends on nothing; every other file in hw/rtl imports it.
package mns_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_NOTE  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_CLOCK = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_INTRO_LEN  = 2'd0;
    localparam logic [1:0] CFG_MAIN_START = 2'd1;
    localparam logic [1:0] CFG_MAIN_LEN   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam int PITCH_W     = 6;
    localparam int CLOCK_DEPTH = 64;
    localparam int ENTRY_W     = 9;
    localparam logic [3:0] WHOLE_BEATS = 4'hF;

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  write_address;
        logic [7:0]  note_byte;
        logic        whole_flag;
        logic [15:0] clock_value;
    } in_item_t;

    typedef struct packed {
        logic [14:0] half_period;
        logic        new_note;
        logic        in_main;
    } out_item_t;

    // Result handed from the pipeline to the result queue
    typedef struct packed {
        logic      push;
        out_item_t item;
    } res_push_t;

    // Extra ticks a note lasts: 2^n - 1 from the exponent, or 15 for a whole note
    function automatic logic [3:0] beats_of(input logic [ENTRY_W-1:0] entry);
        logic [3:0] b;
        case (entry[7:6])
            2'd0:    b = 4'd0;
            2'd1:    b = 4'd1;
            2'd2:    b = 4'd3;
            default: b = 4'd7;
        endcase
        if (entry[8])
        begin
            b = WHOLE_BEATS;
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/mns_in_if.sv
// Input item channel of the melody note sequencer: valid, ready and payload.
// Depends on mns_pkg.
interface mns_in_if;
    import mns_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/mns_out_if.sv
// Result item channel of the melody note sequencer: valid, ready and payload.
// Depends on mns_pkg.
interface mns_out_if;
    import mns_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/mns_out_fifo.sv
// Small result queue that decouples the sequencer pipeline from the output channel.
// Depends on mns_pkg and mns_out_if.
module mns_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  mns_pkg::res_push_t res,
    output logic [mns_pkg::OUT_CNT_W-1:0] count,
    mns_out_if.source          out_ch
);
    import mns_pkg::*;

    out_item_t              slots_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;

    assign pop          = out_ch.valid && out_ch.ready;
    assign out_ch.valid = (count_reg != '0);
    assign out_ch.data  = slots_reg[rd_ptr_reg];
    assign count        = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (res.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!res.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            slots_reg[wr_ptr_reg] <= res.item;
        end
    end

    // The credit check upstream must never let a result arrive into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> (count_reg != OUT_CNT_W'(OUT_DEPTH)))
        else $error("result pushed into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (res.push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !res.push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

FILE: hw/rtl/melody_note_sequencer.sv
// Top level of one melody voice: note store, tone clock table, play control.
// Depends on mns_pkg, mns_in_if, mns_out_if and mns_out_fifo.
//
//  channel   direction  handshake           payload
//  in_ch     sink       valid/ready         operation, write_address, note_byte,
//                                           whole_flag, clock_value
//  out_ch    source     valid/ready         half_period, new_note, in_main
//  cfg       sink       cfg_write (no wait) cfg_index, cfg_data
//
// Flow: an item's result passes stage B, stage C and the result queue before it
// is offered on out_ch. Writes and count-down ticks are taken one per cycle
// while input is not held off; an item that fetches a note (a start, or a tick
// at beat count zero) holds off the next item until the beat count it sets is
// loaded from the note store read.
// The fetch path is note store read -> clock table read -> result queue.
// Reset: asynchronous, active low; clears play position, beat count, section,
// period and the registers to their defaults. Both memories are undefined
// until written and get no clearing pass, so the block is ready at once.
// Stalls: results wait in a four-entry queue; input stalls if queue and items in
// flight would fill it. The user must keep NOTE_DEPTH a power of two (unchecked).
module melody_note_sequencer #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    mns_in_if.sink    in_ch,
    mns_out_if.source out_ch,
    input  logic                               cfg_write,
    input  logic [mns_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mns_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mns_pkg::*;

    localparam int AW = $clog2(NOTE_DEPTH);
    // Wide enough for main_start plus play position and for any store address
    localparam int SW = (AW > 10) ? AW : 10;

    // Configuration registers
    logic [8:0] intro_len_reg;
    logic [7:0] main_start_reg;
    logic [8:0] main_len_reg;

    // Play state
    logic [8:0]  pos_reg;
    logic        main_flag_reg;
    logic [3:0]  beat_reg;
    logic [14:0] period_reg;

    // Stage B: note store data is valid
    logic vb_reg;
    logic b_fetch_reg;
    logic b_main_reg;
    // Stage C: clock table data is valid
    logic vc_reg;
    logic c_fetch_reg;
    logic c_main_reg;
    logic c_rest_reg;

    // Memories and their read registers
    logic [ENTRY_W-1:0] note_mem [NOTE_DEPTH];
    logic [15:0]        clk_mem  [CLOCK_DEPTH];
    logic [ENTRY_W-1:0] note_q;
    logic [15:0]        clk_q;

    // Stage A decode
    logic [1:0]    op;
    logic          in_fire;
    logic          is_fetch;
    logic [8:0]    limit;
    logic          wrap;
    logic [8:0]    pos_base;
    logic          main_new;
    logic [SW-1:0] main_sum;
    logic [SW-1:0] pos_ext;
    logic [SW-1:0] waddr_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          b_busy;

    logic [14:0]          new_period;
    res_push_t            res;
    logic [OUT_CNT_W-1:0] q_count;
    logic [OUT_CNT_W:0]   in_flight;

    assign op      = in_ch.data.operation;
    assign in_fire = in_ch.valid && in_ch.ready;

    // A fetch sitting in stage B still owes the beat count: hold input off
    assign b_busy    = vb_reg && b_fetch_reg;
    assign in_flight = {1'b0, q_count} + {{OUT_CNT_W{1'b0}}, vb_reg}
                     + {{OUT_CNT_W{1'b0}}, vc_reg};
    assign in_ch.ready = !b_busy && (in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH));

    // Decide whether this item fetches, and where play goes next
    always_comb
    begin
        limit    = main_flag_reg ? main_len_reg : intro_len_reg;
        wrap     = (pos_reg >= limit);
        is_fetch = 1'b0;
        pos_base = pos_reg;
        main_new = main_flag_reg;
        unique case (op)
            OP_TICK:
            begin
                if (beat_reg == 4'd0)
                begin
                    is_fetch = 1'b1;
                    if (wrap)
                    begin
                        pos_base = 9'd0;
                        main_new = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                is_fetch = 1'b1;
                pos_base = 9'd0;
                main_new = 1'b0;
            end
            OP_NOTE:  ;
            OP_CLOCK: ;
        endcase
    end

    // Store addresses wrap modulo the store depth
    assign pos_ext   = {{(SW-9){1'b0}}, pos_base};
    assign main_sum  = {{(SW-8){1'b0}}, main_start_reg} + pos_ext;
    assign rd_addr   = main_new ? main_sum[AW-1:0] : pos_ext[AW-1:0];
    assign waddr_ext = {{(SW-8){1'b0}}, in_ch.data.write_address};
    assign wr_addr   = waddr_ext[AW-1:0];

    // Note store: write a note entry, or read the entry a fetch needs
    always_ff @(posedge clk)
    begin
        if (in_fire && (op == OP_NOTE))
        begin
            note_mem[wr_addr] <= {in_ch.data.whole_flag, in_ch.data.note_byte};
        end
        if (in_fire && is_fetch)
        begin
            note_q <= note_mem[rd_addr];
        end
    end

    // Clock table: read at the pitch of the note fetched in the cycle before.
    // No item is taken while that read is pending, so a write never collides.
    always_ff @(posedge clk)
    begin
        if (in_fire && (op == OP_CLOCK))
        begin
            clk_mem[in_ch.data.write_address[PITCH_W-1:0]] <= in_ch.data.clock_value;
        end
        if (b_busy)
        begin
            clk_q <= clk_mem[note_q[PITCH_W-1:0]];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intro_len_reg  <= 9'd31;
            main_start_reg <= 8'd31;
            main_len_reg   <= 9'd212;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INTRO_LEN:  intro_len_reg  <= cfg_data;
                CFG_MAIN_START: main_start_reg <= cfg_data[7:0];
                CFG_MAIN_LEN:   main_len_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Rest notes (pitch zero) are silent; otherwise use half the table value
    assign new_period = c_rest_reg ? 15'd0 : clk_q[15:1];

    // Play state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 9'd0;
            main_flag_reg <= 1'b0;
            beat_reg      <= 4'd0;
            period_reg    <= 15'd0;
            vb_reg        <= 1'b0;
            b_fetch_reg   <= 1'b0;
            b_main_reg    <= 1'b0;
            vc_reg        <= 1'b0;
            c_fetch_reg   <= 1'b0;
            c_main_reg    <= 1'b0;
            c_rest_reg    <= 1'b0;
        end
        else
        begin
            // Stage A: advance position and section at once
            if (in_fire && is_fetch)
            begin
                pos_reg       <= pos_base + 9'd1;
                main_flag_reg <= main_new;
            end

            // Beat count: load from the fetched note, or count down on a tick
            if (b_busy)
            begin
                beat_reg <= beats_of(note_q);
            end
            else if (in_fire && (op == OP_TICK) && (beat_reg != 4'd0))
            begin
                beat_reg <= beat_reg - 4'd1;
            end

            vb_reg      <= in_fire;
            b_fetch_reg <= in_fire && is_fetch;
            b_main_reg  <= (in_fire && is_fetch) ? main_new : main_flag_reg;

            vc_reg      <= vb_reg;
            c_fetch_reg <= b_busy;
            c_main_reg  <= b_main_reg;
            c_rest_reg  <= (note_q[PITCH_W-1:0] == '0);

            // Stage C: the current period changes only on a fetch
            if (vc_reg && c_fetch_reg)
            begin
                period_reg <= new_period;
            end
        end
    end

    // Form the result in order at stage C
    always_comb
    begin
        res.push             = vc_reg;
        res.item.half_period = c_fetch_reg ? new_period : period_reg;
        res.item.new_note    = c_fetch_reg;
        res.item.in_main     = c_main_reg;
    end

    mns_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .count  (q_count),
        .out_ch (out_ch)
    );

    // A fetch in stage B always reaches stage C in the next cycle
    a_fetch_flows: assert property (@(posedge clk) disable iff (!rst_n)
        b_busy |=> (vc_reg && c_fetch_reg))
        else $error("fetch lost between note and clock reads");

    // Only a start returns play to the intro section
    a_main_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(main_flag_reg) |-> $past(in_fire && (op == OP_START)))
        else $error("section fell back to intro without a start");

    // A count-down tick lowers the beat count by exactly one
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == OP_TICK) && (beat_reg != 4'd0))
        |=> (beat_reg == $past(beat_reg) - 4'd1))
        else $error("beat count did not step down");

endmodule

FILE: dv/mns_voice_checker.sv
// Watches the item and result channels of one melody voice and checks every result.
// Holds its own copy of the note store, clock table, play state and registers.
// Depends on mns_pkg, mns_in_if and mns_out_if.
module mns_voice_checker #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mns_in_if                               in_ch,
    mns_out_if                              out_ch,
    input  logic                            cfg_write,
    input  logic [mns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mns_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              outstanding,
    output int                              failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import mns_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [ENTRY_W-1:0] note_mem [NOTE_DEPTH];
    logic [15:0]        tone_clocks [CLOCK_DEPTH];
    logic [8:0]         position;
    logic [3:0]         beats_left;
    logic               main_section;
    logic [14:0]        tone_half;
    logic [8:0]         intro_len;
    logic [7:0]         main_base;
    logic [8:0]         main_len;

    out_item_t          voice_results_due [$];
    int                 mismatch_count;

    // Read the note at the play position, set its length and tone, advance.
    function automatic void load_next_note();
        int                 addr;
        logic [ENTRY_W-1:0] entry;
        logic [5:0]         pitch;
        if (main_section)
        begin
            addr = (int'(main_base) + int'(position)) % NOTE_DEPTH;
        end
        else
        begin
            addr = int'(position) % NOTE_DEPTH;
        end
        entry = note_mem[addr];
        pitch = entry[PITCH_W-1:0];
        if (entry[8])
        begin
            beats_left = WHOLE_BEATS;
        end
        else
        begin
            beats_left = (4'd1 << entry[7:6]) - 4'd1;
        end
        tone_half = (pitch != '0) ? tone_clocks[pitch][15:1] : '0;
        position  = position + 9'd1;
    endfunction

    function automatic out_item_t voice_step(input in_item_t it);
        out_item_t  res;
        logic [8:0] limit;
        res.new_note = 1'b0;
        case (it.operation)
            OP_TICK:
            begin
                if (beats_left == 4'd0)
                begin
                    limit = main_section ? main_len : intro_len;
                    if (position >= limit)
                    begin
                        main_section = 1'b1;
                        position     = '0;
                    end
                    load_next_note();
                    res.new_note = 1'b1;
                end
                else
                begin
                    beats_left = beats_left - 4'd1;
                end
            end
            OP_NOTE:
            begin
                note_mem[int'(it.write_address) % NOTE_DEPTH] = {it.whole_flag, it.note_byte};
            end
            OP_START:
            begin
                position     = '0;
                beats_left   = '0;
                main_section = 1'b0;
                load_next_note();
                res.new_note = 1'b1;
            end
            OP_CLOCK:
            begin
                tone_clocks[it.write_address[PITCH_W-1:0]] = it.clock_value;
            end
        endcase
        res.half_period = tone_half;
        res.in_main     = main_section;
        return res;
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            position       = '0;
            beats_left     = '0;
            main_section   = 1'b0;
            tone_half      = '0;
            intro_len      = 9'd31;
            main_base      = 8'd31;
            main_len       = 9'd212;
            mismatch_count = 0;
            voice_results_due.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INTRO_LEN:  intro_len = cfg_data;
                    CFG_MAIN_START: main_base = cfg_data[7:0];
                    CFG_MAIN_LEN:   main_len  = cfg_data;
                    default:        ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                voice_results_due.push_back(voice_step(in_ch.data));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (voice_results_due.size() == 0)
                begin
                    log_failure($sformatf({"unexpected result half_period=%h ",
                                           "new_note=%b in_main=%b"},
                                          got.half_period, got.new_note, got.in_main));
                end
                else
                begin
                    want = voice_results_due.pop_front();
                    if (got.half_period !== want.half_period || got.new_note !== want.new_note ||
                        got.in_main !== want.in_main)
                    begin
                        log_failure($sformatf({"result mismatch: expected half_period=%h ",
                                               "new_note=%b in_main=%b, got %h %b %b"},
                                              want.half_period, want.new_note, want.in_main,
                                              got.half_period, got.new_note, got.in_main));
                    end
                end
            end
            outstanding <= voice_results_due.size();
            failures    <= mismatch_count;
        end
    end

endmodule

FILE: dv/tb.sv
// Top of the melody voice testbench: clock, reset, item and register stimulus, verdict.
// Drives melody_note_sequencer and hands checking to mns_voice_checker.
// Depends on mns_pkg, mns_in_if, mns_out_if and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mns_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int NOTE_DEPTH   = 256;
    // Longest run of cycles with no handshake on either side before giving up
    localparam int STALL_LIMIT  = 2000;
    // Long receiver hold-off: fills the result queue and backs up the input
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AT      = 600;
    // Quiet cycles after the last result, well past the block's latency
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 120;

    logic clk = 1'b0;
    logic rst_n;

    mns_in_if  in_ch ();
    mns_out_if out_ch ();

    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int outstanding;
    int failures;

    // Idle percentages of the two sides, changed by the stimulus between phases
    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;

    melody_note_sequencer #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mns_voice_checker #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) voice_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Build an item of the given operation; fields it ignores carry random noise.
    function automatic in_item_t random_item(input logic [1:0] op);
        in_item_t it;
        it.operation     = op;
        it.write_address = 8'($urandom);
        it.note_byte     = 8'($urandom);
        it.whole_flag    = 1'($urandom);
        it.clock_value   = 16'($urandom);
        return it;
    endfunction

    // Note entry with a fixed content, for the directed part.
    function automatic in_item_t note_entry(input logic [7:0] addr, input logic [7:0] nbyte,
                                            input logic whole);
        in_item_t it;
        it               = random_item(OP_NOTE);
        it.write_address = addr;
        it.note_byte     = nbyte;
        it.whole_flag    = whole;
        return it;
    endfunction

    function automatic in_item_t clock_entry(input logic [7:0] addr, input logic [15:0] value);
        in_item_t it;
        it               = random_item(OP_CLOCK);
        it.write_address = addr;
        it.clock_value   = value;
        return it;
    endfunction

    // Random note entry, weighted toward short notes so play gets through
    // the intro and around the main loop; rests and whole notes now and then.
    function automatic in_item_t random_note(input logic [7:0] addr);
        int          pick;
        logic [1:0]  expo;
        logic [5:0]  pitch;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            expo = 2'd0;
        end
        else if (pick < 8)
        begin
            expo = 2'd1;
        end
        else if (pick < 9)
        begin
            expo = 2'd2;
        end
        else
        begin
            expo = 2'd3;
        end
        pitch = ($urandom_range(9) == 0) ? 6'd0 : 6'($urandom_range(63));
        return note_entry(addr, {expo, pitch}, $urandom_range(19) == 0);
    endfunction

    // Offer one item and hold it until the block takes it. Random idle
    // cycles go in front of it; valid stays high between back-to-back items.
    task automatic push_item(input in_item_t it);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Drop valid and wait until every result sent so far has come back.
    // The first edge lets the checker count the last item taken.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write all three registers on consecutive cycles, enable held throughout.
    task automatic write_config(input int intro, input int base, input int span);
        cfg_write <= 1'b1;
        cfg_index <= CFG_INTRO_LEN;
        cfg_data  <= CFG_DATA_W'(intro);
        @(posedge clk);
        cfg_index <= CFG_MAIN_START;
        cfg_data  <= CFG_DATA_W'(base);
        @(posedge clk);
        cfg_index <= CFG_MAIN_LEN;
        cfg_data  <= CFG_DATA_W'(span);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One random phase: new section layout, usually a fresh start, then mostly
    // ticks with note and clock rewrites and stray starts mixed in.
    task automatic run_phase(input int intro, input int base, input int span, input int count);
        int k;
        int pick;
        wait_idle();
        write_config(intro, base, span);
        if ($urandom_range(9) != 0)
        begin
            push_item(random_item(OP_START));
        end
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                push_item(random_item(OP_TICK));
            end
            else if (pick < 90)
            begin
                push_item(random_note(8'($urandom)));
            end
            else if (pick < 95)
            begin
                push_item(random_item(OP_CLOCK));
            end
            else
            begin
                push_item(random_item(OP_START));
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off while the sender
    // keeps offering items, so the queue fills and input backs up.
    initial
    begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // End the run when neither channel has moved an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int a;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_pct = 22;
        rx_idle_pct = 84;
        items_sent  = 0;
        rst_n       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Fill both stores first: no fetch may ever read an unwritten entry.
        // Clock writes put noise in the index's unused top bits.
        for (a = 0; a < CLOCK_DEPTH; a++)
        begin
            push_item(clock_entry({2'($urandom), 6'(a)}, 16'($urandom)));
        end
        for (a = 0; a < NOTE_DEPTH; a++)
        begin
            push_item(random_note(8'(a)));
        end

        // Directed, reset layout: clock extremes (largest value, one that
        // halves to zero, top bit only), a maximal pitch, the longest
        // exponent, a whole-note rest, then a start in mid count-down.
        push_item(clock_entry(8'hFF, 16'hFFFF));
        push_item(clock_entry(8'h41, 16'h0001));
        push_item(clock_entry(8'h82, 16'h8000));
        push_item(note_entry(8'h00, 8'h3F, 1'b0));
        push_item(note_entry(8'h01, 8'hC1, 1'b0));
        push_item(note_entry(8'h02, 8'h00, 1'b1));
        push_item(note_entry(8'h03, 8'h42, 1'b0));
        push_item(note_entry(8'hFF, 8'h7F, 1'b0));
        push_item(random_item(OP_START));
        push_item(random_item(OP_TICK));
        push_item(random_item(OP_TICK));
        push_item(random_item(OP_TICK));
        push_item(random_item(OP_TICK));
        push_item(random_item(OP_START));
        push_item(random_item(OP_TICK));

        // Directed, short sections: main section starts at the top address
        // and wraps to zero, then loops back to its first note.
        wait_idle();
        write_config(2, 255, 3);
        push_item(note_entry(8'h01, 8'h02, 1'b0));
        push_item(random_item(OP_START));
        for (a = 0; a < 8; a++)
        begin
            push_item(random_item(OP_TICK));
        end

        // Random phases, sender mostly busy and receiver mostly stalled.
        // Cover empty intro, address wrap, minimal and maximal sections.
        run_phase(0, 17, 5, PHASE_ITEMS);
        run_phase(3, 250, 9, PHASE_ITEMS);
        run_phase(1, 0, 1, PHASE_ITEMS);
        run_phase(256, 0, 256, PHASE_ITEMS);

        // Swap the idle rates: sender sparse, receiver mostly ready.
        tx_idle_pct = 84;
        rx_idle_pct = 22;
        run_phase(5, 100, 0, PHASE_ITEMS);
        run_phase(8, 255, 256, PHASE_ITEMS);
        run_phase(0, 0, 0, PHASE_ITEMS);

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(4, 60, 12, PHASE_ITEMS);
        run_phase(2, 128, 7, PHASE_ITEMS);
        run_phase(16, 200, 40, PHASE_ITEMS);
        run_phase($urandom_range(1, 12), $urandom_range(255), $urandom_range(1, 16), PHASE_ITEMS);

        // Drain, then give any stray result time to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: melody_note_sequencer.f
hw/rtl/mns_pkg.sv
hw/rtl/mns_in_if.sv
hw/rtl/mns_out_if.sv
hw/rtl/mns_out_fifo.sv
hw/rtl/melody_note_sequencer.sv
dv/mns_voice_checker.sv
dv/tb.sv
